// ===== hdl/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [PrioW-1:0]  prio;
  } cell_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// one slot of the sorted chain: keeps, takes the new entry, or shifts
`timescale 1ns / 1ps
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_cmd_t               cmd,
  input  logic signed [spq_pkg::ValueW-1:0] new_value,
  input  logic                             occupied,
  input  logic                             left_stays,
  input  logic signed [spq_pkg::ValueW-1:0] left_value,
  input  logic signed [spq_pkg::PrioW-1:0]  left_prio,
  input  logic signed [spq_pkg::ValueW-1:0] right_value,
  input  logic signed [spq_pkg::PrioW-1:0]  right_prio,
  output logic signed [spq_pkg::ValueW-1:0] value_r,
  output logic signed [spq_pkg::PrioW-1:0]  prio_r,
  output logic                             stays
);
  import spq_pkg::*;

  // entry here is ahead of the incoming one, equal priorities stay ahead
  assign stays = occupied && (prio_r <= cmd.prio);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!stays) begin
        if (left_stays) begin
          value_r <= new_value;
          prio_r  <= cmd.prio;
        end else begin
          value_r <= left_value;
          prio_r  <= left_prio;
        end
      end
    end else if (cmd.del) begin
      value_r <= right_value;
      prio_r  <= right_prio;
    end
  end

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
// sorted priority queue top level: chain of compare-and-shift cells
// the result of an accepted request is registered in the output register
// throughput: one request per cycle while the output is taken, every cell decides in parallel
// the output register holds a result until taken; a new request is taken in the same cycle
// reset clears the entry count and output valid; slot contents are not cleared
`timescale 1ns / 1ps
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // entry_value[31:0], entry_priority[47:32]
  input  logic [0:0]  in_tuser,  // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // removed_value[31:0], status[33:32], queue_empty[34], zero
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  logic [ValueW-1:0] removed_r, removed_nxt;
  status_t         status_r, status_nxt;
  logic            empty_r, empty_nxt;

  logic accept, is_del, full, empty_now;
  cell_cmd_t cmd;
  logic signed [ValueW-1:0] new_value;

  logic signed [ValueW-1:0] cell_value [QUEUE_DEPTH];
  logic signed [PrioW-1:0]  cell_prio  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_stays;
  logic [QUEUE_DEPTH-1:0]   cell_occ;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_del    = (in_tuser[0] == OP_DELETE);
  assign new_value = in_tdata[31:0];
  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign empty_now = (count_r == '0);

  // ins, del, prio
  assign cmd = {accept && !is_del && !full, accept && is_del && !empty_now, in_tdata[47:32]};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_stays;
    logic signed [ValueW-1:0] l_value, r_value;
    logic signed [PrioW-1:0]  l_prio, r_prio;

    assign cell_occ[i] = (CntW'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_stays = 1'b1;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_stays = cell_stays[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_value   (new_value),
      .occupied    (cell_occ[i]),
      .left_stays  (l_stays),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_value (r_value),
      .right_prio  (r_prio),
      .value_r     (cell_value[i]),
      .prio_r      (cell_prio[i]),
      .stays       (cell_stays[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = ST_OK;
    if (is_del) begin
      if (empty_now) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        removed_nxt = cell_value[0];
        count_nxt   = count_r - CntW'(1);
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CntW'(1);
      end
    end
    empty_nxt = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      empty_r   <= empty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, empty_r, status_r, removed_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_del && empty_now |=> status_r == ST_UNDERFLOW && empty_r && removed_r == '0)
    else $error("delete on empty queue not flagged");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_del && full |=> count_r == CntW'(QUEUE_DEPTH) && status_r == ST_FULL)
    else $error("insert into full queue changed state");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(accept) |-> empty_r == (count_r == '0))
    else $error("empty flag disagrees with entry count");
`endif

endmodule
